FILE: rtl/core/rlss_pkg.sv
// Shared types and constants of the RGB LED strip serializer.
// Holds the request codes, the decoded request format and the register set.
// No dependencies; every other file refers to it by scoped names.
package rlss_pkg;

    // Field widths
    localparam int KIND_W      = 2;
    localparam int BYTE_W      = 8;
    localparam int WORD_W      = 24;
    localparam int CFG_INDEX_W = 2;
    localparam int SUM_W       = 10;

    // Frame format
    localparam int BITS_PER_LED = 24;
    localparam int BIT_POS_W    = 5;

    // Decoupling queue between front and back
    localparam int QUEUE_DEPTH = 4;

    // Divide by three through a reciprocal: exact for an 8-bit index
    // (x * 171) >> 9, and for a 10-bit color sum (x * 683) >> 11
    localparam int DIV3_IDX_MUL   = 171;
    localparam int DIV3_IDX_SHIFT = 9;
    localparam int DIV3_SUM_MUL   = 683;
    localparam int DIV3_SUM_SHIFT = 11;

    // Request kinds on the input channel
    localparam logic [KIND_W-1:0] KIND_WRITE  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_UPDATE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_TICK   = 2'd2;

    // Register indexes of the configuration port
    localparam logic [CFG_INDEX_W-1:0] CFG_CHANNEL_MODE = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_ZERO_HIGH    = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_ONE_HIGH     = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_BIT_PERIOD   = 2'd3;

    // Register reset values
    localparam logic [BYTE_W-1:0] ZERO_HIGH_RESET  = 8'd5;
    localparam logic [BYTE_W-1:0] ONE_HIGH_RESET   = 8'd12;
    localparam logic [BYTE_W-1:0] BIT_PERIOD_RESET = 8'd20;

    // Color component selected by a byte index
    localparam logic [1:0] COMP_RED   = 2'd0;
    localparam logic [1:0] COMP_GREEN = 2'd1;

    // Decoded operation handed from front to back
    typedef enum logic [2:0] {
        OP_NOP    = 3'd0,
        OP_COLOR  = 3'd1,
        OP_BYTE   = 3'd2,
        OP_UPDATE = 3'd3,
        OP_TICK   = 3'd4
    } op_t;

    // Decoded request; word is green:red:blue for a color, the low byte
    // carries the averaged value for a byte write
    typedef struct packed {
        op_t               op;
        logic              in_range;
        logic [1:0]        comp;
        logic [WORD_W-1:0] word;
    } item_t;

    // Register set
    typedef struct packed {
        logic              channel_mode;
        logic [BYTE_W-1:0] zero_high_ticks;
        logic [BYTE_W-1:0] one_high_ticks;
        logic [BYTE_W-1:0] bit_period_ticks;
    } cfg_t;

endpackage

FILE: rtl/core/rlss_front.sv
// Front end of the LED strip serializer: takes requests and decodes them.
// Splits byte indexes, averages colors and range-checks buffer addresses.
// Depends on rlss_pkg.
module rlss_front #(
    parameter int LED_NUMBER = 32,
    parameter int AW         = 5
) (
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [rlss_pkg::KIND_W-1:0]      s_kind,
    input  logic [rlss_pkg::BYTE_W-1:0]      s_index,
    input  logic [rlss_pkg::BYTE_W-1:0]      s_red,
    input  logic [rlss_pkg::BYTE_W-1:0]      s_green,
    input  logic [rlss_pkg::BYTE_W-1:0]      s_blue,
    input  rlss_pkg::cfg_t                   cfg,
    input  logic                             q_full,
    output logic                             q_push,
    output rlss_pkg::item_t                  q_item,
    output logic [AW-1:0]                    q_addr
);

    logic [15:0]                     idx_prod;
    logic [6:0]                      byte_led;
    logic [7:0]                      byte_led_x3;
    logic [1:0]                      byte_comp;
    logic [rlss_pkg::SUM_W-1:0]      color_sum;
    logic [19:0]                     sum_prod;
    logic [rlss_pkg::BYTE_W-1:0]     color_avg;
    logic                            led_in_range;
    logic                            byte_in_range;

    // Accept while the queue has room
    assign s_ready = !q_full;
    assign q_push  = s_valid && !q_full;

    // Byte index to LED number and component
    assign idx_prod    = {8'd0, s_index} * 16'(rlss_pkg::DIV3_IDX_MUL);
    assign byte_led    = idx_prod[15:rlss_pkg::DIV3_IDX_SHIFT];
    assign byte_led_x3 = {byte_led, 1'b0} + {1'b0, byte_led};
    assign byte_comp   = 2'(s_index - byte_led_x3);

    // Average of the three components
    assign color_sum = rlss_pkg::SUM_W'(s_red) + rlss_pkg::SUM_W'(s_green)
                     + rlss_pkg::SUM_W'(s_blue);
    assign sum_prod  = {10'd0, color_sum} * 20'(rlss_pkg::DIV3_SUM_MUL);
    assign color_avg = sum_prod[rlss_pkg::DIV3_SUM_SHIFT +: rlss_pkg::BYTE_W];

    assign led_in_range  = s_index < 8'(LED_NUMBER);
    assign byte_in_range = byte_led < 7'(LED_NUMBER);

    // Classify the request
    always_comb begin
        q_item.op       = rlss_pkg::OP_NOP;
        q_item.in_range = 1'b0;
        q_item.comp     = byte_comp;
        q_item.word     = {s_green, s_red, s_blue};
        q_addr          = '0;
        case (s_kind)
            rlss_pkg::KIND_WRITE: begin
                if (cfg.channel_mode) begin
                    q_item.op       = rlss_pkg::OP_BYTE;
                    q_item.in_range = byte_in_range;
                    q_item.word     = {16'd0, color_avg};
                    if (byte_in_range) begin
                        q_addr = byte_led[AW-1:0];
                    end
                end else begin
                    q_item.op       = rlss_pkg::OP_COLOR;
                    q_item.in_range = led_in_range;
                    if (led_in_range) begin
                        q_addr = s_index[AW-1:0];
                    end
                end
            end
            rlss_pkg::KIND_UPDATE: begin
                q_item.op = rlss_pkg::OP_UPDATE;
            end
            rlss_pkg::KIND_TICK: begin
                q_item.op = rlss_pkg::OP_TICK;
            end
            default: begin
                q_item.op = rlss_pkg::OP_NOP;
            end
        endcase
    end

endmodule

FILE: rtl/core/rlss_queue.sv
// Short request queue between the front and back of the LED strip serializer.
// Register slots with read and write pointers and an occupancy count.
// Depends on rlss_pkg for its depth.
module rlss_queue #(
    parameter int DATA_W = 8
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  logic [DATA_W-1:0] push_data,
    input  logic              pop,
    output logic [DATA_W-1:0] head_data,
    output logic              empty,
    output logic              full
);

    localparam int DEPTH = rlss_pkg::QUEUE_DEPTH;
    localparam int PW    = $clog2(DEPTH);

    logic [DATA_W-1:0] slot_reg [DEPTH];
    logic [PW-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [PW:0]       count_reg, count_next;

    assign head_data = slot_reg[rd_ptr_reg];
    assign empty     = count_reg == '0;
    assign full      = count_reg == (PW+1)'(DEPTH);

    // Advance pointers and count
    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the pushed request
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

FILE: rtl/core/rlss_back.sv
// Back end of the LED strip serializer: frame buffer, bit timer, result register.
// Executes one decoded request per cycle unless the receiver stalls, and holds
// the result for the receiver. Depends on rlss_pkg.
module rlss_back #(
    parameter int LED_NUMBER = 32,
    parameter int AW         = 5
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  rlss_pkg::cfg_t   cfg,
    input  logic             q_empty,
    input  rlss_pkg::item_t  q_item,
    input  logic [AW-1:0]    q_addr,
    output logic             q_pop,
    output logic             m_valid,
    input  logic             m_ready,
    output logic             m_line_level,
    output logic             m_busy_res
);

    localparam int WW = rlss_pkg::WORD_W;
    localparam int BW = rlss_pkg::BIT_POS_W;

    // Execute stage
    logic                  exec_valid_reg, exec_valid_next;
    rlss_pkg::item_t       exec_item_reg;
    logic [AW-1:0]         exec_addr_reg;
    logic                  exec_fire;
    logic                  exec_load;

    // Frame buffer with per-entry valid bits
    logic [WW-1:0]         mem [0:LED_NUMBER-1];
    logic [LED_NUMBER-1:0] valid_reg;
    logic [AW-1:0]         rd1_addr, rd2_addr;
    logic [WW-1:0]         rd1_data_reg, rd2_data_reg;
    logic                  rd1_valid_reg, rd2_valid_reg;
    logic [AW-1:0]         rd2_addr_reg;
    logic                  fwd_valid_reg;
    logic [AW-1:0]         fwd_addr_reg;
    logic [WW-1:0]         fwd_data_reg;
    logic [WW-1:0]         eff1, eff2;
    logic                  wr_en;
    logic [WW-1:0]         wr_data;

    // Transmitter state
    logic                  dirty_reg, dirty_next;
    logic                  sending_reg, sending_next;
    logic [AW-1:0]         led_reg, led_next;
    logic [BW-1:0]         bit_reg, bit_next;
    logic [7:0]            phase_reg, phase_next;
    logic [WW-1:0]         shift_reg, shift_next;
    logic [8:0]            phase_inc;
    logic [AW:0]           led_inc;
    logic [AW:0]           prefetch_led;
    logic [7:0]            high_ticks;
    logic                  line_next;

    // Result register
    logic                  m_valid_reg;
    logic                  m_line_level_reg;
    logic                  m_busy_res_reg;

    assign m_valid      = m_valid_reg;
    assign m_line_level = m_line_level_reg;
    assign m_busy_res   = m_busy_res_reg;

    // Advance when the result register is free or being drained
    assign exec_fire       = exec_valid_reg && (!m_valid_reg || m_ready);
    assign exec_load       = !exec_valid_reg || exec_fire;
    assign q_pop           = exec_load && !q_empty;
    assign exec_valid_next = exec_load ? !q_empty : exec_valid_reg;

    // Read the entry of the request that sits in execute next cycle
    assign rd1_addr = q_pop ? q_addr : exec_addr_reg;

    // Merge the write of the last edge over the registered read data
    assign eff1 = (fwd_valid_reg && fwd_addr_reg == exec_addr_reg) ? fwd_data_reg
                : (rd1_valid_reg ? rd1_data_reg : '0);
    assign eff2 = (fwd_valid_reg && fwd_addr_reg == rd2_addr_reg) ? fwd_data_reg
                : (rd2_valid_reg ? rd2_data_reg : '0);

    assign phase_inc = {1'b0, phase_reg} + 9'd1;
    assign led_inc   = {1'b0, led_reg} + (AW+1)'(1);

    // Execute the request
    always_comb begin
        dirty_next   = dirty_reg;
        sending_next = sending_reg;
        led_next     = led_reg;
        bit_next     = bit_reg;
        phase_next   = phase_reg;
        shift_next   = shift_reg;
        wr_en        = 1'b0;
        wr_data      = eff1;
        if (exec_fire) begin
            case (exec_item_reg.op)
                rlss_pkg::OP_COLOR: begin
                    if (exec_item_reg.in_range && eff1 != exec_item_reg.word) begin
                        wr_en      = 1'b1;
                        wr_data    = exec_item_reg.word;
                        dirty_next = 1'b1;
                    end
                end
                rlss_pkg::OP_BYTE: begin
                    if (exec_item_reg.in_range) begin
                        wr_en      = 1'b1;
                        dirty_next = 1'b1;
                        case (exec_item_reg.comp)
                            rlss_pkg::COMP_RED:   wr_data[15:8]  = exec_item_reg.word[7:0];
                            rlss_pkg::COMP_GREEN: wr_data[23:16] = exec_item_reg.word[7:0];
                            default:              wr_data[7:0]   = exec_item_reg.word[7:0];
                        endcase
                    end
                end
                rlss_pkg::OP_UPDATE: begin
                    if (dirty_reg && !sending_reg) begin
                        dirty_next   = 1'b0;
                        sending_next = 1'b1;
                        led_next     = '0;
                        bit_next     = '0;
                        phase_next   = '0;
                        shift_next   = eff2;
                    end
                end
                rlss_pkg::OP_TICK: begin
                    if (sending_reg) begin
                        if (phase_inc < {1'b0, cfg.bit_period_ticks}) begin
                            phase_next = phase_inc[7:0];
                        end else begin
                            phase_next = '0;
                            shift_next = {shift_reg[WW-2:0], 1'b0};
                            if (bit_reg == BW'(rlss_pkg::BITS_PER_LED - 1)) begin
                                bit_next = '0;
                                if (led_inc >= (AW+1)'(LED_NUMBER)) begin
                                    sending_next = 1'b0;
                                    led_next     = '0;
                                    shift_next   = '0;
                                end else begin
                                    led_next   = led_inc[AW-1:0];
                                    shift_next = eff2;
                                end
                            end else begin
                                bit_next = bit_reg + 1'b1;
                            end
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Prefetch the LED that the next load will take
    assign prefetch_led = {1'b0, led_next} + (AW+1)'(1);
    assign rd2_addr = (sending_next && prefetch_led < (AW+1)'(LED_NUMBER))
                    ? prefetch_led[AW-1:0] : '0;

    // Line level after this request
    assign high_ticks = shift_next[WW-1] ? cfg.one_high_ticks : cfg.zero_high_ticks;
    assign line_next  = sending_next && (phase_next < high_ticks);

    // Frame buffer write and two registered reads
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[exec_addr_reg] <= wr_data;
        end
        rd1_data_reg  <= mem[rd1_addr];
        rd2_data_reg  <= mem[rd2_addr];
        rd1_valid_reg <= valid_reg[rd1_addr];
        rd2_valid_reg <= valid_reg[rd2_addr];
        rd2_addr_reg  <= rd2_addr;
        fwd_addr_reg  <= exec_addr_reg;
        fwd_data_reg  <= wr_data;
    end

    // Execute stage payload
    always_ff @(posedge aclk) begin
        if (q_pop) begin
            exec_item_reg <= q_item;
            exec_addr_reg <= q_addr;
        end
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            exec_valid_reg   <= 1'b0;
            valid_reg        <= '0;
            fwd_valid_reg    <= 1'b0;
            dirty_reg        <= 1'b0;
            sending_reg      <= 1'b0;
            led_reg          <= '0;
            bit_reg          <= '0;
            phase_reg        <= '0;
            shift_reg        <= '0;
            m_valid_reg      <= 1'b0;
            m_line_level_reg <= 1'b0;
            m_busy_res_reg   <= 1'b0;
        end else begin
            exec_valid_reg <= exec_valid_next;
            fwd_valid_reg  <= wr_en;
            if (wr_en) begin
                valid_reg[exec_addr_reg] <= 1'b1;
            end
            dirty_reg   <= dirty_next;
            sending_reg <= sending_next;
            led_reg     <= led_next;
            bit_reg     <= bit_next;
            phase_reg   <= phase_next;
            shift_reg   <= shift_next;
            // Hold the result until the receiver takes it
            if (exec_fire) begin
                m_valid_reg      <= 1'b1;
                m_line_level_reg <= line_next;
                m_busy_res_reg   <= sending_next;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    a_idle_counters_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        !sending_reg |-> (led_reg == '0 && bit_reg == '0 && phase_reg == '0
                          && shift_reg == '0))
        else $error("transmitter counters not cleared while idle");

    a_bit_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        bit_reg < BW'(rlss_pkg::BITS_PER_LED))
        else $error("bit position beyond one LED");

    a_frame_start_clears_dirty: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(sending_reg) |-> !dirty_reg)
        else $error("frame started without clearing dirty");

    a_line_only_when_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_line_level_reg) |-> m_busy_res_reg)
        else $error("line driven high outside a frame");

    a_forward_from_commit: assert property (@(posedge aclk) disable iff (!aresetn)
        fwd_valid_reg |-> $past(exec_fire))
        else $error("buffer write without an executed request");

endmodule

FILE: rtl/core/rgb_led_strip_serializer_unit.sv
// Top level of the RGB LED strip serializer: register set and the
// front end, request queue and back end. Depends on rlss_pkg, rlss_front,
// rlss_queue and rlss_back.
//
// Usage: requests enter on the s_ channel (kind, index, red, green, blue);
// a write stores a color (or one averaged byte in channel mode), an update
// starts a frame if idle and the buffer changed, and a tick advances the
// bit timer by one tick. Every request returns exactly one result on the
// m_ channel: the data line level and the busy flag after that request.
// Registers are written on the cfg_ channel, index 0 channel mode, 1 zero
// high ticks, 2 one high ticks, 3 bit period; cfg_ready is always high.
// An accepted request passes the queue, execute stage and result register.
// Throughput is one request per cycle while m_ready is high, set by the
// single execute stage and the one write port of the frame buffer.
// Reset clears the registers to their defaults and the frame buffer to all
// zero at once through per-LED valid bits; no clearing pass is needed.
// When the receiver stalls, the result register holds and a four-entry
// queue keeps taking requests; s_ready drops when the queue is full.
module rgb_led_strip_serializer_unit #(
    parameter int LED_NUMBER = 32
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [rlss_pkg::KIND_W-1:0]         s_kind,
    input  logic [rlss_pkg::BYTE_W-1:0]         s_index,
    input  logic [rlss_pkg::BYTE_W-1:0]         s_red,
    input  logic [rlss_pkg::BYTE_W-1:0]         s_green,
    input  logic [rlss_pkg::BYTE_W-1:0]         s_blue,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic                                m_line_level,
    output logic                                m_busy_res,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [rlss_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [rlss_pkg::BYTE_W-1:0]         cfg_data
);

    localparam int AW     = (LED_NUMBER > 1) ? $clog2(LED_NUMBER) : 1;
    localparam int ITEM_W = $bits(rlss_pkg::item_t);
    localparam int Q_W    = ITEM_W + AW;

    rlss_pkg::cfg_t   cfg_reg;
    rlss_pkg::item_t  f_item;
    logic [AW-1:0]    f_addr;
    logic             q_push;
    logic             q_pop;
    logic             q_full;
    logic             q_empty;
    logic [Q_W-1:0]   q_head;
    rlss_pkg::item_t  q_item;
    logic [AW-1:0]    q_addr;

    assign cfg_ready = 1'b1;

    // Register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.channel_mode     <= 1'b0;
            cfg_reg.zero_high_ticks  <= rlss_pkg::ZERO_HIGH_RESET;
            cfg_reg.one_high_ticks   <= rlss_pkg::ONE_HIGH_RESET;
            cfg_reg.bit_period_ticks <= rlss_pkg::BIT_PERIOD_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                rlss_pkg::CFG_CHANNEL_MODE: cfg_reg.channel_mode     <= cfg_data[0];
                rlss_pkg::CFG_ZERO_HIGH:    cfg_reg.zero_high_ticks  <= cfg_data;
                rlss_pkg::CFG_ONE_HIGH:     cfg_reg.one_high_ticks   <= cfg_data;
                rlss_pkg::CFG_BIT_PERIOD:   cfg_reg.bit_period_ticks <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    rlss_front #(
        .LED_NUMBER (LED_NUMBER),
        .AW         (AW)
    ) u_front (
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_kind  (s_kind),
        .s_index (s_index),
        .s_red   (s_red),
        .s_green (s_green),
        .s_blue  (s_blue),
        .cfg     (cfg_reg),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_item  (f_item),
        .q_addr  (f_addr)
    );

    rlss_queue #(
        .DATA_W (Q_W)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data ({f_addr, f_item}),
        .pop       (q_pop),
        .head_data (q_head),
        .empty     (q_empty),
        .full      (q_full)
    );

    // Split the queue head into request and buffer address
    assign q_item = rlss_pkg::item_t'(q_head[ITEM_W-1:0]);
    assign q_addr = q_head[Q_W-1:ITEM_W];

    rlss_back #(
        .LED_NUMBER (LED_NUMBER),
        .AW         (AW)
    ) u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg          (cfg_reg),
        .q_empty      (q_empty),
        .q_item       (q_item),
        .q_addr       (q_addr),
        .q_pop        (q_pop),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_line_level (m_line_level),
        .m_busy_res   (m_busy_res)
    );

endmodule
